// File: rtl/gdts_pkg.sv
// Shared types and constants for the grid derivative stencil unit.
`timescale 1ns / 1ps

package gdts_pkg;

    localparam int SAMPLE_W  = 32;
    localparam int WEIGHT_W  = 32;
    localparam int DIFF_W    = 35;
    localparam int FULLP_W   = WEIGHT_W + DIFF_W;
    localparam int FRAC_W    = 16;
    localparam int PROD_W    = FULLP_W - FRAC_W;
    localparam int TERM_W    = 48;
    localparam int SIZE_W    = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;
    localparam int N_TERMS   = 4;

    // Term slots inside a work record
    localparam int TERM_XX = 0;
    localparam int TERM_YY = 1;
    localparam int TERM_X  = 2;
    localparam int TERM_Y  = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_G_PER_POINT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_G_WEIGHT       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PHI_PER_POINT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PHI_WEIGHT     = 3'd4;

    // Input item kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_FLUSH  = 1'b1;

    localparam logic [SIZE_W-1:0]   GRID_SIZE_RST = 7'd64;
    localparam logic [SIZE_W-1:0]   SIDE_MIN      = 7'd3;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RST    = 32'd65536;

    // One sample with its per-point weights
    typedef struct packed {
        logic [SAMPLE_W-1:0] g;
        logic [SAMPLE_W-1:0] phi;
        logic [WEIGHT_W-1:0] g_w;
        logic [WEIGHT_W-1:0] phi_w;
    } t_tap;

    typedef struct packed {
        logic [SAMPLE_W-1:0] g;
        logic [SAMPLE_W-1:0] phi;
    } t_pair;

    // Differences and weights of one point, front to back
    typedef struct packed {
        logic [N_TERMS-1:0][DIFF_W-1:0] g_diff;
        logic [N_TERMS-1:0][DIFF_W-1:0] phi_diff;
        logic [WEIGHT_W-1:0]            g_weight;
        logic [WEIGHT_W-1:0]            phi_weight;
        logic                           last;
    } t_work;

endpackage

// File: rtl/gdts_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module gdts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/gdts_front.sv
// Front part: configuration, point counters, line buffers and stencil differences.
`timescale 1ns / 1ps

module gdts_front #(
    parameter int GRID_MAX = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [gdts_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [gdts_pkg::CFG_DAT_W-1:0]      i_cfg_wdata,
    input  logic                                i_accept,
    input  logic                                i_kind,
    input  logic [gdts_pkg::SAMPLE_W-1:0]       i_g_sample,
    input  logic [gdts_pkg::SAMPLE_W-1:0]       i_phi_sample,
    input  logic [gdts_pkg::WEIGHT_W-1:0]       i_g_weight_sample,
    input  logic [gdts_pkg::WEIGHT_W-1:0]       i_phi_weight_sample,
    output logic                                o_push,
    output gdts_pkg::t_work                     o_work
);

    localparam int CNT_W     = $clog2(GRID_MAX * GRID_MAX + 1);
    localparam int LB1_DEPTH = GRID_MAX - 1;
    localparam int LB2_DEPTH = GRID_MAX;
    localparam int LB1_AW    = $clog2(LB1_DEPTH);
    localparam int LB2_AW    = $clog2(LB2_DEPTH);
    localparam int SIDE_CAP_I = (GRID_MAX > 127) ? 127 : GRID_MAX;
    localparam logic [gdts_pkg::SIZE_W-1:0] SIDE_CAP = gdts_pkg::SIZE_W'(SIDE_CAP_I);

    // Configuration
    logic [gdts_pkg::SIZE_W-1:0]   r_grid_size;
    logic                          r_g_per_point;
    logic [gdts_pkg::WEIGHT_W-1:0] r_g_weight;
    logic                          r_phi_per_point;
    logic [gdts_pkg::WEIGHT_W-1:0] r_phi_weight;

    // Stream position
    logic [CNT_W-1:0]              r_smp_cnt;
    logic [gdts_pkg::SIZE_W-1:0]   r_col;
    logic [gdts_pkg::SIZE_W-1:0]   r_row;
    logic [LB1_AW-1:0]             r_ptr1;
    logic [LB2_AW-1:0]             r_ptr2;
    logic [LB1_AW-1:0]             n_ptr1;
    logic [LB2_AW-1:0]             n_ptr2;

    // Window taps
    gdts_pkg::t_tap                r_q0;
    gdts_pkg::t_tap                r_q1;
    gdts_pkg::t_pair               r_q2;
    gdts_pkg::t_tap                lb1_rd;
    gdts_pkg::t_pair               lb2_rd;
    gdts_pkg::t_pair               lb2_wr;

    logic [gdts_pkg::SIZE_W-1:0]   side;
    logic [CNT_W-1:0]              total;
    logic                          is_sample;
    logic                          grid_full;
    logic                          advance;
    logic                          emit;
    logic                          col_first;
    logic                          col_last;
    logic                          row_first;
    logic                          row_last;
    logic                          cfg_grid;

    function automatic logic [gdts_pkg::N_TERMS-1:0][gdts_pkg::DIFF_W-1:0] stencil(
        input logic [gdts_pkg::SAMPLE_W-1:0] pn,
        input logic [gdts_pkg::SAMPLE_W-1:0] p1,
        input logic [gdts_pkg::SAMPLE_W-1:0] pc,
        input logic [gdts_pkg::SAMPLE_W-1:0] m1,
        input logic [gdts_pkg::SAMPLE_W-1:0] mn,
        input logic c_first,
        input logic c_last,
        input logic w_first,
        input logic w_last
    );
        logic signed [gdts_pkg::DIFF_W-1:0] e_pn;
        logic signed [gdts_pkg::DIFF_W-1:0] e_p1;
        logic signed [gdts_pkg::DIFF_W-1:0] e_pc;
        logic signed [gdts_pkg::DIFF_W-1:0] e_m1;
        logic signed [gdts_pkg::DIFF_W-1:0] e_mn;
        logic [gdts_pkg::N_TERMS-1:0][gdts_pkg::DIFF_W-1:0] d;
        e_pn = {{(gdts_pkg::DIFF_W - gdts_pkg::SAMPLE_W){pn[gdts_pkg::SAMPLE_W-1]}}, pn};
        e_p1 = {{(gdts_pkg::DIFF_W - gdts_pkg::SAMPLE_W){p1[gdts_pkg::SAMPLE_W-1]}}, p1};
        e_pc = {{(gdts_pkg::DIFF_W - gdts_pkg::SAMPLE_W){pc[gdts_pkg::SAMPLE_W-1]}}, pc};
        e_m1 = {{(gdts_pkg::DIFF_W - gdts_pkg::SAMPLE_W){m1[gdts_pkg::SAMPLE_W-1]}}, m1};
        e_mn = {{(gdts_pkg::DIFF_W - gdts_pkg::SAMPLE_W){mn[gdts_pkg::SAMPLE_W-1]}}, mn};
        // Border lines mirror the one neighbor and have no central difference
        if (c_first) begin
            d[gdts_pkg::TERM_XX] = (e_p1 - e_pc) <<< 1;
            d[gdts_pkg::TERM_X]  = '0;
        end else if (c_last) begin
            d[gdts_pkg::TERM_XX] = (e_m1 - e_pc) <<< 1;
            d[gdts_pkg::TERM_X]  = '0;
        end else begin
            d[gdts_pkg::TERM_XX] = e_p1 + e_m1 - (e_pc <<< 1);
            d[gdts_pkg::TERM_X]  = e_p1 - e_m1;
        end
        if (w_first) begin
            d[gdts_pkg::TERM_YY] = (e_pn - e_pc) <<< 1;
            d[gdts_pkg::TERM_Y]  = '0;
        end else if (w_last) begin
            d[gdts_pkg::TERM_YY] = (e_mn - e_pc) <<< 1;
            d[gdts_pkg::TERM_Y]  = '0;
        end else begin
            d[gdts_pkg::TERM_YY] = e_pn + e_mn - (e_pc <<< 1);
            d[gdts_pkg::TERM_Y]  = e_pn - e_mn;
        end
        return d;
    endfunction

    always_comb begin
        if (r_grid_size < gdts_pkg::SIDE_MIN) begin
            side = gdts_pkg::SIDE_MIN;
        end else if (r_grid_size > SIDE_CAP) begin
            side = SIDE_CAP;
        end else begin
            side = r_grid_size;
        end
    end

    assign total     = CNT_W'(32'(side) * 32'(side));
    assign is_sample = (i_kind == gdts_pkg::KIND_SAMPLE);
    assign grid_full = (r_smp_cnt >= total);
    // A sample on a full grid and a flush before the grid is full do nothing
    assign advance   = i_accept && (is_sample ? !grid_full : grid_full);
    assign emit      = i_accept && (is_sample
                       ? (!grid_full && (32'(r_smp_cnt) > 32'(side))) : grid_full);
    assign cfg_grid  = i_cfg_wr_en && (i_cfg_idx == gdts_pkg::CFG_GRID_SIZE);

    assign col_first = (r_col == '0);
    assign col_last  = (32'(r_col) == 32'(side) - 32'd1);
    assign row_first = (r_row == '0);
    assign row_last  = (32'(r_row) == 32'(side) - 32'd1);

    // Line buffer 1 delays by side-1, line buffer 2 by side
    assign n_ptr1 = (32'(r_ptr1) == 32'(side) - 32'd2) ? '0 : r_ptr1 + LB1_AW'(1);
    assign n_ptr2 = (32'(r_ptr2) == 32'(side) - 32'd1) ? '0 : r_ptr2 + LB2_AW'(1);

    assign lb2_wr.g   = r_q1.g;
    assign lb2_wr.phi = r_q1.phi;

    gdts_ram #(
        .WIDTH ($bits(gdts_pkg::t_tap)),
        .DEPTH (LB1_DEPTH)
    ) u_lb1 (
        .i_clk   (i_clk),
        .i_we    (advance),
        .i_waddr (r_ptr1),
        .i_wdata (r_q0),
        .i_re    (advance),
        .i_raddr (n_ptr1),
        .o_rdata (lb1_rd)
    );

    gdts_ram #(
        .WIDTH ($bits(gdts_pkg::t_pair)),
        .DEPTH (LB2_DEPTH)
    ) u_lb2 (
        .i_clk   (i_clk),
        .i_we    (advance),
        .i_waddr (r_ptr2),
        .i_wdata (lb2_wr),
        .i_re    (advance),
        .i_raddr (n_ptr2),
        .o_rdata (lb2_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size     <= gdts_pkg::GRID_SIZE_RST;
            r_g_per_point   <= 1'b0;
            r_g_weight      <= gdts_pkg::WEIGHT_RST;
            r_phi_per_point <= 1'b0;
            r_phi_weight    <= gdts_pkg::WEIGHT_RST;
            r_smp_cnt       <= '0;
            r_col           <= '0;
            r_row           <= '0;
            r_ptr1          <= '0;
            r_ptr2          <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                gdts_pkg::CFG_GRID_SIZE:     r_grid_size     <= i_cfg_wdata[gdts_pkg::SIZE_W-1:0];
                gdts_pkg::CFG_G_PER_POINT:   r_g_per_point   <= i_cfg_wdata[0];
                gdts_pkg::CFG_G_WEIGHT:      r_g_weight      <= i_cfg_wdata;
                gdts_pkg::CFG_PHI_PER_POINT: r_phi_per_point <= i_cfg_wdata[0];
                gdts_pkg::CFG_PHI_WEIGHT:    r_phi_weight    <= i_cfg_wdata;
                default: ;
            endcase
            // Restart the stream on a new grid size
            if (cfg_grid) begin
                r_smp_cnt <= '0;
                r_col     <= '0;
                r_row     <= '0;
                r_ptr1    <= '0;
                r_ptr2    <= '0;
            end
        end else begin
            if (advance) begin
                r_ptr1 <= n_ptr1;
                r_ptr2 <= n_ptr2;
                if (is_sample) begin
                    r_smp_cnt <= r_smp_cnt + CNT_W'(1);
                end
            end
            if (emit) begin
                if (col_last && row_last) begin
                    r_smp_cnt <= '0;
                    r_col     <= '0;
                    r_row     <= '0;
                end else if (col_last) begin
                    r_col <= '0;
                    r_row <= r_row + gdts_pkg::SIZE_W'(1);
                end else begin
                    r_col <= r_col + gdts_pkg::SIZE_W'(1);
                end
            end
        end
    end

    // Window shift; a flush shifts in a don't-care value past the grid end
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_q0.g     <= i_g_sample;
            r_q0.phi   <= i_phi_sample;
            r_q0.g_w   <= i_g_weight_sample;
            r_q0.phi_w <= i_phi_weight_sample;
            r_q1       <= lb1_rd;
            r_q2.g     <= r_q1.g;
            r_q2.phi   <= r_q1.phi;
        end
    end

    assign o_push = emit;

    always_comb begin
        o_work.g_diff     = stencil(r_q0.g, lb1_rd.g, r_q1.g, r_q2.g, lb2_rd.g,
                                    col_first, col_last, row_first, row_last);
        o_work.phi_diff   = stencil(r_q0.phi, lb1_rd.phi, r_q1.phi, r_q2.phi, lb2_rd.phi,
                                    col_first, col_last, row_first, row_last);
        o_work.g_weight   = r_g_per_point ? r_q1.g_w : r_g_weight;
        o_work.phi_weight = r_phi_per_point ? r_q1.phi_w : r_phi_weight;
        o_work.last       = col_last && row_last;
    end

endmodule

// File: rtl/gdts_queue.sv
// Short queue of work records between front and back.
`timescale 1ns / 1ps

module gdts_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  gdts_pkg::t_work i_work,
    output logic            o_full,
    output logic            o_vld,
    output gdts_pkg::t_work o_work,
    input  logic            i_pop
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    gdts_pkg::t_work r_mem [DEPTH];
    logic [AW-1:0]   r_head;
    logic [AW-1:0]   r_tail;
    logic [CW-1:0]   r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (32'(r_count) == DEPTH);
    assign o_vld   = (r_count != '0);
    assign o_work  = r_mem[r_head];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_tail <= (32'(r_tail) == DEPTH - 1) ? '0 : r_tail + AW'(1);
            end
            if (do_pop) begin
                r_head <= (32'(r_head) == DEPTH - 1) ? '0 : r_head + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_tail] <= i_work;
        end
    end

endmodule

// File: rtl/gdts_back.sv
// Back part: weight products, g plus phi sums with saturation, result register.
`timescale 1ns / 1ps

module gdts_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_vld,
    input  gdts_pkg::t_work              i_work,
    output logic                         o_take,
    output logic                         empty,
    input  logic                         pop,
    output logic [gdts_pkg::TERM_W-1:0]  o_second_x_term,
    output logic [gdts_pkg::TERM_W-1:0]  o_second_y_term,
    output logic [gdts_pkg::TERM_W-1:0]  o_first_x_term,
    output logic [gdts_pkg::TERM_W-1:0]  o_first_y_term,
    output logic                         o_last_point
);

    localparam int SUM_W = gdts_pkg::PROD_W + 1;

    logic                                r_m_vld;
    logic signed [gdts_pkg::PROD_W-1:0]  r_m_g   [gdts_pkg::N_TERMS];
    logic signed [gdts_pkg::PROD_W-1:0]  r_m_phi [gdts_pkg::N_TERMS];
    logic                                r_m_last;
    logic                                r_s_vld;
    logic [gdts_pkg::TERM_W-1:0]         r_s_term [gdts_pkg::N_TERMS];
    logic                                r_s_last;

    logic signed [gdts_pkg::PROD_W-1:0]  n_m_g   [gdts_pkg::N_TERMS];
    logic signed [gdts_pkg::PROD_W-1:0]  n_m_phi [gdts_pkg::N_TERMS];
    logic [gdts_pkg::TERM_W-1:0]         n_s_term [gdts_pkg::N_TERMS];
    logic                                s_en;
    logic                                m_en;

    assign s_en   = !r_s_vld || pop;
    assign m_en   = !r_m_vld || s_en;
    assign o_take = m_en && i_vld;

    // Exact product, then floor to Q35.16 by dropping the low fraction bits
    always_comb begin
        logic signed [gdts_pkg::FULLP_W-1:0] pg;
        logic signed [gdts_pkg::FULLP_W-1:0] pp;
        for (int k = 0; k < gdts_pkg::N_TERMS; k++) begin
            pg = $signed(i_work.g_weight) * $signed(i_work.g_diff[k]);
            pp = $signed(i_work.phi_weight) * $signed(i_work.phi_diff[k]);
            n_m_g[k]   = pg[gdts_pkg::FULLP_W-1:gdts_pkg::FRAC_W];
            n_m_phi[k] = pp[gdts_pkg::FULLP_W-1:gdts_pkg::FRAC_W];
        end
    end

    // Sum and clamp to signed 48 bits
    always_comb begin
        logic signed [SUM_W-1:0] sum;
        for (int k = 0; k < gdts_pkg::N_TERMS; k++) begin
            sum = {r_m_g[k][gdts_pkg::PROD_W-1], r_m_g[k]}
                + {r_m_phi[k][gdts_pkg::PROD_W-1], r_m_phi[k]};
            if (sum[SUM_W-1:gdts_pkg::TERM_W-1] == '0
                    || sum[SUM_W-1:gdts_pkg::TERM_W-1] == '1) begin
                n_s_term[k] = sum[gdts_pkg::TERM_W-1:0];
            end else if (sum[SUM_W-1]) begin
                n_s_term[k] = {1'b1, {(gdts_pkg::TERM_W-1){1'b0}}};
            end else begin
                n_s_term[k] = {1'b0, {(gdts_pkg::TERM_W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
            r_s_vld <= 1'b0;
        end else begin
            if (m_en) begin
                r_m_vld <= i_vld;
            end
            if (s_en) begin
                r_s_vld <= r_m_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_m_g    <= n_m_g;
            r_m_phi  <= n_m_phi;
            r_m_last <= i_work.last;
        end
        if (s_en && r_m_vld) begin
            r_s_term <= n_s_term;
            r_s_last <= r_m_last;
        end
    end

    assign empty           = !r_s_vld;
    assign o_second_x_term = r_s_term[gdts_pkg::TERM_XX];
    assign o_second_y_term = r_s_term[gdts_pkg::TERM_YY];
    assign o_first_x_term  = r_s_term[gdts_pkg::TERM_X];
    assign o_first_y_term  = r_s_term[gdts_pkg::TERM_Y];
    assign o_last_point    = r_s_last;

endmodule

// File: rtl/grid_derivative_term_stencil_unit.sv
// Top level of the grid derivative stencil unit.
`timescale 1ns / 1ps

// Streams g and phi over a square grid in row order and returns, per point, the
// weighted x/y second-difference and central-difference sums (Q32.16, saturated).
// One item is taken per clock cycle as long as results are popped; the rate is set
// by the two line-buffer RAMs, each written and read once per point. The result for
// a point is computed when the sample one row plus one point later (or a flush once
// the grid is full) is pushed, and then passes through the queue, a multiply stage
// and a sum/saturate stage to the result ports. A queue of QUEUE_DEPTH
// records lets input keep flowing while results wait. Push exactly N*N samples and
// then N+1 flushes per grid; a write to grid_size restarts the stream. No clearing
// pass is needed after reset.

module grid_derivative_term_stencil_unit #(
    parameter int GRID_MAX    = 64,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [gdts_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [gdts_pkg::CFG_DAT_W-1:0]      i_cfg_wdata,
    input  logic                                push,
    output logic                                full,
    input  logic                                i_kind,
    input  logic [gdts_pkg::SAMPLE_W-1:0]       i_g_sample,
    input  logic [gdts_pkg::SAMPLE_W-1:0]       i_phi_sample,
    input  logic [gdts_pkg::WEIGHT_W-1:0]       i_g_weight_sample,
    input  logic [gdts_pkg::WEIGHT_W-1:0]       i_phi_weight_sample,
    output logic                                empty,
    input  logic                                pop,
    output logic [gdts_pkg::TERM_W-1:0]         o_second_x_term,
    output logic [gdts_pkg::TERM_W-1:0]         o_second_y_term,
    output logic [gdts_pkg::TERM_W-1:0]         o_first_x_term,
    output logic [gdts_pkg::TERM_W-1:0]         o_first_y_term,
    output logic                                o_last_point
);

    logic            accept;
    logic            fr_push;
    gdts_pkg::t_work fr_work;
    logic            q_vld;
    gdts_pkg::t_work q_work;
    logic            bk_take;

    assign accept = push && !full;

    gdts_front #(
        .GRID_MAX (GRID_MAX)
    ) u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_accept            (accept),
        .i_kind              (i_kind),
        .i_g_sample          (i_g_sample),
        .i_phi_sample        (i_phi_sample),
        .i_g_weight_sample   (i_g_weight_sample),
        .i_phi_weight_sample (i_phi_weight_sample),
        .o_push              (fr_push),
        .o_work              (fr_work)
    );

    gdts_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_push),
        .i_work  (fr_work),
        .o_full  (full),
        .o_vld   (q_vld),
        .o_work  (q_work),
        .i_pop   (bk_take)
    );

    gdts_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_vld           (q_vld),
        .i_work          (q_work),
        .o_take          (bk_take),
        .empty           (empty),
        .pop             (pop),
        .o_second_x_term (o_second_x_term),
        .o_second_y_term (o_second_y_term),
        .o_first_x_term  (o_first_x_term),
        .o_first_y_term  (o_first_y_term),
        .o_last_point    (o_last_point)
    );

endmodule

// File: rtl/gdts_checker.sv
// Port-level checks for the grid derivative stencil unit, bound to the top level.
`timescale 1ns / 1ps

module gdts_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    input  logic                                full,
    input  logic                                empty,
    input  logic                                pop,
    input  logic [gdts_pkg::TERM_W-1:0]         o_second_x_term,
    input  logic [gdts_pkg::TERM_W-1:0]         o_second_y_term,
    input  logic [gdts_pkg::TERM_W-1:0]         o_first_x_term,
    input  logic [gdts_pkg::TERM_W-1:0]         o_first_y_term,
    input  logic                                o_last_point
);

    // Reset drops all pending results
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result pending right after reset");

    // Reset leaves room for input
    a_rst_not_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input blocked right after reset");

    // Nothing comes out of reset without a transaction on the input
    a_no_spurious: assert property (@(posedge i_clk) !i_rst_n ##1 !push |=> empty)
        else $error("result appeared without an input transaction");

    // Input side only fills on an input transaction
    a_full_needs_push: assert property (@(posedge i_clk) (!full && !push) |=> !full)
        else $error("full raised without an input transaction");

    // A waiting result holds until taken
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_second_x_term)
            && $stable(o_second_y_term) && $stable(o_first_x_term)
            && $stable(o_first_y_term) && $stable(o_last_point)))
        else $error("waiting result changed before it was taken");

endmodule

bind grid_derivative_term_stencil_unit gdts_checker u_gdts_checker (.*);
